// ===== hdl/fpmd_pkg.sv =====
// Shared constants and types for the fixed-point multiply/divide unit.
package fpmd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam logic KIND_MUL = 1'b0;
	localparam logic KIND_DIV = 1'b1;

	// per-transaction control that rides along the pipeline
	typedef struct packed {
		logic kind;
		logic neg;
		logic sat;
	} ctl_t;

endpackage

// ===== hdl/fpmd_div_step.sv =====
// One restoring-division stage: retires one quotient bit per transaction.
module fpmd_div_step #(
	parameter int WORD_BITS = fpmd_pkg::WORD_BITS_DEF,
	parameter int QUO_BITS  = 2 * fpmd_pkg::FRAC_BITS_DEF - 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  fpmd_pkg::ctl_t       ctl_in,
	input  logic [WORD_BITS-1:0] mul_in,
	input  logic [WORD_BITS:0]   mb_in,
	input  logic [WORD_BITS:0]   rem_in,
	input  logic [QUO_BITS-1:0]  dvd_in,
	output logic                 v_out,
	output fpmd_pkg::ctl_t       ctl_out,
	output logic [WORD_BITS-1:0] mul_out,
	output logic [WORD_BITS:0]   mb_out,
	output logic [WORD_BITS:0]   rem_out,
	output logic [QUO_BITS-1:0]  dvd_out
);

	logic [WORD_BITS+1:0] rem_ext;
	logic [WORD_BITS+2:0] diff;
	logic                 qbit;
	logic [WORD_BITS:0]   rem_nxt;
	logic [QUO_BITS-1:0]  dvd_nxt;

	logic                 v_sd;
	fpmd_pkg::ctl_t       ctl_sd;
	logic [WORD_BITS-1:0] mul_sd;
	logic [WORD_BITS:0]   mb_sd;
	logic [WORD_BITS:0]   rem_sd;
	logic [QUO_BITS-1:0]  dvd_sd;

	// shift in the next dividend bit, subtract if it fits
	assign rem_ext = {rem_in, dvd_in[QUO_BITS-1]};
	assign diff    = {1'b0, rem_ext} - {2'b00, mb_in};
	assign qbit    = ~diff[WORD_BITS+2];
	assign rem_nxt = qbit ? diff[WORD_BITS:0] : rem_ext[WORD_BITS:0];
	// dividend bits leave at the top, quotient bits enter at the bottom
	assign dvd_nxt = {dvd_in[QUO_BITS-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (en) begin
			v_sd <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sd <= ctl_in;
			mul_sd <= mul_in;
			mb_sd  <= mb_in;
			rem_sd <= rem_nxt;
			dvd_sd <= dvd_nxt;
		end
	end

	assign v_out   = v_sd;
	assign ctl_out = ctl_sd;
	assign mul_out = mul_sd;
	assign mb_out  = mb_sd;
	assign rem_out = rem_sd;
	assign dvd_out = dvd_sd;

endmodule

// ===== hdl/fixed_point_mul_div.sv =====
// Top level of the signed fixed-point multiply/divide pipeline.
//
// Signed fixed-point multiply/divide unit (Q16.16 by default). One transaction
// per cycle is accepted while op_stall is low, and each yields one result, in
// order. The register stages are an input register, a stage holding the signed
// product and operand magnitudes, a stage for the divide overflow check,
// 2*FRAC_BITS-2 restoring-division stages of one quotient bit each, and the
// output register. Every stage has its own valid bit, so empty slots are filled
// while res_stall is high, and op_stall rises only when every stage holds a
// transaction. Multiply returns the product shifted right arithmetically by
// FRAC_BITS, wrapped to the word. Divide clamps to the most positive or most
// negative word and sets saturated when |a| >> (FRAC_BITS-2) >= |b| (divisor
// zero included); otherwise it returns (a << FRAC_BITS) / b truncated toward
// zero.
module fixed_point_mul_div #(
	parameter int FRAC_BITS = fpmd_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = fpmd_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_valid,
	output logic                        op_stall,
	input  logic                        kind,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic signed [WORD_BITS-1:0] result,
	output logic                        saturated
);

	localparam int QUO_BITS = 2 * FRAC_BITS - 2;
	localparam int DVD_BITS = WORD_BITS + 1 + FRAC_BITS + QUO_BITS;
	localparam int GUARD_SH = FRAC_BITS - 2;

	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

	// stage 1: operands
	logic                        v_s1;
	logic                        kind_s1;
	logic signed [WORD_BITS-1:0] a_s1;
	logic signed [WORD_BITS-1:0] b_s1;

	// stage 2: product and magnitudes
	logic                          v_s2;
	fpmd_pkg::ctl_t                ctl_s2;
	logic signed [2*WORD_BITS-1:0] prod_s2;
	logic [WORD_BITS:0]            ma_s2;
	logic [WORD_BITS:0]            mb_s2;

	// stage 3: overflow check, divider seed
	logic                 v_s3;
	fpmd_pkg::ctl_t       ctl_s3;
	logic [WORD_BITS-1:0] mul_s3;
	logic [WORD_BITS:0]   mb_s3;
	logic [WORD_BITS:0]   rem_s3;
	logic [QUO_BITS-1:0]  dvd_s3;

	// stage 4: output register, after the divide stages
	logic                 v_s4;
	logic [WORD_BITS-1:0] result_s4;
	logic                 sat_s4;

	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic rdy_s4;

	logic signed [2*WORD_BITS-1:0] prod_c;
	logic [WORD_BITS:0]            ma_c;
	logic [WORD_BITS:0]            mb_c;
	logic [DVD_BITS-1:0]           dvd_full;
	logic                          guard_c;

	// divide chain: index 0 is stage 3, index k+1 the output of step k
	logic                 v_d   [0:QUO_BITS];
	fpmd_pkg::ctl_t       ctl_d [0:QUO_BITS];
	logic [WORD_BITS-1:0] mul_d [0:QUO_BITS];
	logic [WORD_BITS:0]   mb_d  [0:QUO_BITS];
	logic [WORD_BITS:0]   rem_d [0:QUO_BITS];
	logic [QUO_BITS-1:0]  dvd_d [0:QUO_BITS];
	logic                 rdy_d [0:QUO_BITS];

	logic [WORD_BITS-1:0] quo_w;
	logic [WORD_BITS-1:0] quo_signed;
	logic [WORD_BITS-1:0] result_c;
	logic                 sat_c;

	// ready ripples back; a stage loads when empty or when its successor moves
	assign rdy_s4   = ~v_s4 | ~res_stall;
	assign rdy_d[QUO_BITS] = rdy_s4;
	assign rdy_s3   = ~v_s3 | rdy_d[0];
	assign rdy_s2   = ~v_s2 | rdy_s3;
	assign rdy_s1   = ~v_s1 | rdy_s2;
	assign op_stall = ~rdy_s1;

	// ---------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			kind_s1 <= kind;
			a_s1    <= a;
			b_s1    <= b;
		end
	end

	// ---------------- stage 2
	assign prod_c = a_s1 * b_s1;
	// one bit wider than the word, so the most negative value is exact
	assign ma_c = a_s1[WORD_BITS-1] ? ((WORD_BITS+1)'(0) - {a_s1[WORD_BITS-1], a_s1})
	                                : {1'b0, a_s1};
	assign mb_c = b_s1[WORD_BITS-1] ? ((WORD_BITS+1)'(0) - {b_s1[WORD_BITS-1], b_s1})
	                                : {1'b0, b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ctl_s2.kind <= kind_s1;
			ctl_s2.neg  <= a_s1[WORD_BITS-1] ^ b_s1[WORD_BITS-1];
			ctl_s2.sat  <= 1'b0;
			prod_s2     <= prod_c;
			ma_s2       <= ma_c;
			mb_s2       <= mb_c;
		end
	end

	// ---------------- stage 3
	assign guard_c  = (ma_s2 >> GUARD_SH) >= mb_s2;
	assign dvd_full = DVD_BITS'({ma_s2, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctl_s3.kind <= ctl_s2.kind;
			ctl_s3.neg  <= ctl_s2.neg;
			ctl_s3.sat  <= (ctl_s2.kind == fpmd_pkg::KIND_DIV) && guard_c;
			mul_s3      <= WORD_BITS'(prod_s2 >>> FRAC_BITS);
			mb_s3       <= mb_s2;
			// without overflow the quotient fits QUO_BITS, so the top part is below |b|
			rem_s3      <= (WORD_BITS+1)'(dvd_full >> QUO_BITS);
			dvd_s3      <= dvd_full[QUO_BITS-1:0];
		end
	end

	assign v_d[0]   = v_s3;
	assign ctl_d[0] = ctl_s3;
	assign mul_d[0] = mul_s3;
	assign mb_d[0]  = mb_s3;
	assign rem_d[0] = rem_s3;
	assign dvd_d[0] = dvd_s3;

	// ---------------- divide stages
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		assign rdy_d[k] = ~v_d[k+1] | rdy_d[k+1];

		fpmd_div_step #(
			.WORD_BITS (WORD_BITS),
			.QUO_BITS  (QUO_BITS)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (rdy_d[k]),
			.v_in    (v_d[k]),
			.ctl_in  (ctl_d[k]),
			.mul_in  (mul_d[k]),
			.mb_in   (mb_d[k]),
			.rem_in  (rem_d[k]),
			.dvd_in  (dvd_d[k]),
			.v_out   (v_d[k+1]),
			.ctl_out (ctl_d[k+1]),
			.mul_out (mul_d[k+1]),
			.mb_out  (mb_d[k+1]),
			.rem_out (rem_d[k+1]),
			.dvd_out (dvd_d[k+1])
		);
	end

	// ---------------- stage 4
	assign quo_w      = WORD_BITS'(dvd_d[QUO_BITS]);
	assign quo_signed = ctl_d[QUO_BITS].neg ? (WORD_BITS'(0) - quo_w) : quo_w;
	assign sat_c      = ctl_d[QUO_BITS].sat;

	always_comb begin
		if (ctl_d[QUO_BITS].kind == fpmd_pkg::KIND_MUL) begin
			result_c = mul_d[QUO_BITS];
		end else if (sat_c) begin
			result_c = ctl_d[QUO_BITS].neg ? WORD_MIN : WORD_MAX;
		end else begin
			result_c = quo_signed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_d[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			result_s4 <= result_c;
			sat_s4    <= sat_c;
		end
	end

	assign res_valid = v_s4;
	assign result    = result_s4;
	assign saturated = sat_s4;

endmodule

// ===== dv/fixed_point_mul_div_test.sv =====
// Self-checking testbench for the signed fixed-point multiply/divide pipeline.
module fixed_point_mul_div_test;

	localparam int W = fpmd_pkg::WORD_BITS_DEF;
	localparam int F = fpmd_pkg::FRAC_BITS_DEF;
	localparam int GUARD_SHIFT = F - 2;
	localparam int DRAIN_CYCLES = 2 * F + 8;
	localparam int RANDOM_PER_PHASE = 200;

	localparam logic signed [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] FX_ONE = 1 <<< F;

	typedef struct packed {
		logic                kind;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
	} arith_op_t;

	typedef struct packed {
		logic signed [W-1:0] result;
		logic                saturated;
	} arith_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                op_valid = 1'b0;
	logic                op_stall;
	logic                kind = fpmd_pkg::KIND_MUL;
	logic signed [W-1:0] a = '0;
	logic signed [W-1:0] b = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic signed [W-1:0] result;
	logic                saturated;

	arith_op_t  pending_ops[$];
	arith_res_t expected_results[$];
	arith_op_t  taken_op;
	arith_res_t want;
	bit         op_taken = 1'b0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         failures = 0;

	fixed_point_mul_div uut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.kind(kind),
		.a(a),
		.b(b),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result(result),
		.saturated(saturated)
	);

	function automatic arith_res_t compute_result(arith_op_t op);
		logic signed [2*W-1:0] pa;
		logic signed [2*W-1:0] pb;
		logic signed [2*W-1:0] prod;
		logic [W:0]            ma;
		logic [W:0]            mb;
		logic [W+F:0]          quo;
		logic                  neg;
		arith_res_t            r;
		r.saturated = 1'b0;
		if (op.kind == fpmd_pkg::KIND_MUL) begin
			pa = {{W{op.a[W-1]}}, op.a};
			pb = {{W{op.b[W-1]}}, op.b};
			prod = pa * pb;
			// arithmetic shift by F, then wrap to the word
			r.result = prod[F+W-1:F];
		end else begin
			neg = op.a[W-1] ^ op.b[W-1];
			// one extra bit so the magnitude of the most negative word fits
			ma = op.a[W-1] ? -{1'b1, op.a} : {1'b0, op.a};
			mb = op.b[W-1] ? -{1'b1, op.b} : {1'b0, op.b};
			if ((ma >> GUARD_SHIFT) >= mb) begin
				r.saturated = 1'b1;
				r.result = neg ? WORD_MIN : WORD_MAX;
			end else begin
				quo = {ma, {F{1'b0}}} / mb;
				if (neg)
					quo = -quo;
				r.result = quo[W-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] random_operand();
		logic signed [W-1:0] w;
		case ($urandom_range(4))
			0, 1: w = $urandom;
			2: begin
				w = $urandom;
				w = w >>> $urandom_range(W - 1);
			end
			3: begin
				case ($urandom_range(7))
					0: w = '0;
					1: w = 1;
					2: w = -1;
					3: w = FX_ONE;
					4: w = -FX_ONE;
					5: w = WORD_MAX;
					6: w = WORD_MIN;
					default: w = WORD_MIN + 1;
				endcase
			end
			default: begin
				w = $urandom_range(255) << F;
				if ($urandom_range(1))
					w = -w;
			end
		endcase
		return w;
	endfunction

	task automatic queue_op(logic k, logic signed [W-1:0] x, logic signed [W-1:0] y);
		arith_op_t op;
		op.kind = k;
		op.a = x;
		op.b = y;
		pending_ops.push_back(op);
	endtask

	task automatic queue_random_ops(int count);
		for (int i = 0; i < count; i++)
			queue_op(1'($urandom_range(1)), random_operand(), random_operand());
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// driver and receiver stall, both on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			op_valid <= 1'b0;
			res_stall <= 1'b0;
		end else begin
			if (!(op_valid && !op_taken)) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					op_valid <= 1'b1;
					kind <= pending_ops[0].kind;
					a <= pending_ops[0].a;
					b <= pending_ops[0].b;
				end else begin
					op_valid <= 1'b0;
				end
			end
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
		op_taken = 1'b0;
	end

	// monitor: predict on accepted transactions, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && !op_stall) begin
				taken_op = pending_ops.pop_front();
				expected_results.push_back(compute_result(taken_op));
				op_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction outstanding: result %h saturated %b",
						result, saturated);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (result !== want.result) begin
						$error("result: expected %h, actual %h", want.result, result);
						failures++;
					end
					if (saturated !== want.saturated) begin
						$error("saturated: expected %b, actual %b", want.saturated, saturated);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 64;

		queue_op(fpmd_pkg::KIND_MUL, WORD_MAX, WORD_MAX);
		queue_op(fpmd_pkg::KIND_MUL, WORD_MIN, WORD_MIN);
		queue_op(fpmd_pkg::KIND_MUL, WORD_MIN, WORD_MAX);
		queue_op(fpmd_pkg::KIND_MUL, WORD_MIN, -1);
		queue_op(fpmd_pkg::KIND_MUL, -1, 1);
		queue_op(fpmd_pkg::KIND_MUL, FX_ONE, -FX_ONE);
		queue_op(fpmd_pkg::KIND_MUL, '0, WORD_MIN);
		// divisor zero, including zero over zero
		queue_op(fpmd_pkg::KIND_DIV, FX_ONE, '0);
		queue_op(fpmd_pkg::KIND_DIV, -FX_ONE, '0);
		queue_op(fpmd_pkg::KIND_DIV, '0, '0);
		queue_op(fpmd_pkg::KIND_DIV, WORD_MIN, -1);
		queue_op(fpmd_pkg::KIND_DIV, WORD_MIN, WORD_MIN);
		queue_op(fpmd_pkg::KIND_DIV, WORD_MAX, WORD_MIN);
		queue_op(fpmd_pkg::KIND_DIV, WORD_MAX, 1);
		queue_op(fpmd_pkg::KIND_DIV, 1, WORD_MAX);
		queue_op(fpmd_pkg::KIND_DIV, FX_ONE, FX_ONE);
		queue_op(fpmd_pkg::KIND_DIV, -FX_ONE, 3 * FX_ONE);
		// clamp boundary: just at and just below the guard
		queue_op(fpmd_pkg::KIND_DIV, 16 <<< GUARD_SHIFT, 16);
		queue_op(fpmd_pkg::KIND_DIV, (16 <<< GUARD_SHIFT) - 1, 16);
		queue_op(fpmd_pkg::KIND_DIV, -(16 <<< GUARD_SHIFT), 16);
		queue_op(fpmd_pkg::KIND_DIV, (16 <<< GUARD_SHIFT) - 1, -16);
		queue_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 64;
		recv_idle_pct = 12;
		queue_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
